// ===== rtl/reed_solomon_parity_encoder_assert.svh =====
// assertion helpers shared by the encoder modules
`ifndef REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RSP_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsp_pkg.sv =====
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int SYMBOL_BITS       = 8;
    localparam int FIELD_ORDER       = (1 << SYMBOL_BITS) - 1;
    localparam int POLY_BITS         = SYMBOL_BITS + 1;
    localparam int RCOUNT_BITS       = 6;
    localparam int IDX_BITS          = 5;
    localparam int MAX_PARITY_DEF    = 32;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = POLY_BITS;
    localparam int FRAME_QUEUE_DEPTH = 2;
    localparam int QPTR_BITS         = $clog2(FRAME_QUEUE_DEPTH);
    localparam int QCOUNT_BITS       = $clog2(FRAME_QUEUE_DEPTH + 1);

    localparam logic [SYMBOL_BITS-1:0] FIELD_ONE       = 8'h01;
    localparam logic [SYMBOL_BITS-1:0] RST_POLY_LOW    = 8'h1D;
    localparam logic [SYMBOL_BITS-1:0] RST_PRIMITIVE   = 8'h02;
    localparam logic [SYMBOL_BITS-1:0] RST_FIRST_ROOT  = 8'h00;
    localparam logic [RCOUNT_BITS-1:0] RST_PARITY_CNT  = 6'd24;
    localparam logic [RCOUNT_BITS-1:0] MIN_PARITY      = 6'd2;

    typedef logic [SYMBOL_BITS-1:0] symbol_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FIELD_POLY   = 3'd0,
        CFG_PRIMITIVE    = 3'd1,
        CFG_FIRST_ROOT   = 3'd2,
        CFG_PARITY_COUNT = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic clear;
    } gen_status_t;

    // shift-and-add product, reduced by x^8 + red
    function automatic symbol_t gf_mul(symbol_t a, symbol_t b, symbol_t red);
        symbol_t acc;
        symbol_t p;
        logic    carry;
        acc = '0;
        p   = a;
        for (int k = 0; k < SYMBOL_BITS; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ p;
            end
            carry = p[SYMBOL_BITS-1];
            p     = {p[SYMBOL_BITS-2:0], 1'b0};
            if (carry)
            begin
                p = p ^ red;
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/rsp_gen.sv =====
`timescale 1ns / 1ps
`include "reed_solomon_parity_encoder_assert.svh"

module rsp_gen #(
    parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_write,
    input  logic [rsp_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
    input  logic [rsp_pkg::CFG_DATA_BITS-1:0]             cfg_data,
    output rsp_pkg::symbol_t                              red,
    output logic [$clog2(MAX_PARITY+1)-1:0]               r_eff,
    output logic [MAX_PARITY-1:0][rsp_pkg::SYMBOL_BITS-1:0] coeff,
    output rsp_pkg::gen_status_t                          status
);
    import rsp_pkg::*;

    localparam int RW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    typedef enum logic [1:0] {
        S_INIT,
        S_POW,
        S_ROOT,
        S_DONE
    } gen_state_t;

    gen_state_t                              state_reg;
    symbol_t                                 poly_reg;
    symbol_t                                 prim_reg;
    symbol_t                                 root_reg;
    logic [RCOUNT_BITS-1:0]                  count_reg;
    symbol_t                                 v_reg;
    symbol_t                                 e_reg;
    logic [IW-1:0]                           i_reg;
    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0]  g_reg;

    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0]  g_next;
    symbol_t                                 v_next;
    symbol_t                                 e_next;
    symbol_t                                 b_mod;
    logic                                    cfg_hit;

    always_comb
    begin
        if (count_reg < MIN_PARITY)
        begin
            r_eff = RW'(MIN_PARITY);
        end
        else if (int'(count_reg) > MAX_PARITY)
        begin
            r_eff = RW'(MAX_PARITY);
        end
        else
        begin
            r_eff = RW'(count_reg);
        end
    end

    assign b_mod   = (root_reg == SYMBOL_BITS'(FIELD_ORDER)) ? '0 : root_reg;
    assign cfg_hit = cfg_write && (cfg_index inside {[CFG_FIELD_POLY:CFG_PARITY_COUNT]});

    // alpha^e walk, exponents wrap at the field order
    always_comb
    begin
        if (e_reg == SYMBOL_BITS'(FIELD_ORDER - 1))
        begin
            v_next = FIELD_ONE;
            e_next = '0;
        end
        else
        begin
            v_next = gf_mul(prim_reg, v_reg, poly_reg);
            e_next = e_reg + 8'd1;
        end
    end

    // multiply running generator by (x + root), all terms at once
    always_comb
    begin
        g_next[0] = gf_mul(g_reg[0], v_reg, poly_reg);
        for (int k = 1; k < MAX_PARITY; k++)
        begin
            g_next[k] = g_reg[k-1] ^ gf_mul(g_reg[k], v_reg, poly_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            poly_reg  <= RST_POLY_LOW;
            prim_reg  <= RST_PRIMITIVE;
            root_reg  <= RST_FIRST_ROOT;
            count_reg <= RST_PARITY_CNT;
            v_reg     <= FIELD_ONE;
            e_reg     <= '0;
            i_reg     <= '0;
            g_reg     <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                CFG_FIELD_POLY:   poly_reg  <= cfg_data[SYMBOL_BITS-1:0];
                CFG_PRIMITIVE:    prim_reg  <= cfg_data[SYMBOL_BITS-1:0];
                CFG_FIRST_ROOT:   root_reg  <= cfg_data[SYMBOL_BITS-1:0];
                CFG_PARITY_COUNT: count_reg <= cfg_data[RCOUNT_BITS-1:0];
                default:          ;
            endcase
            state_reg <= S_INIT;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    v_reg     <= FIELD_ONE;
                    e_reg     <= '0;
                    i_reg     <= '0;
                    g_reg     <= {{(MAX_PARITY-1){SYMBOL_BITS'(0)}}, FIELD_ONE};
                    state_reg <= S_POW;
                end
                S_POW:
                begin
                    if (e_reg == b_mod)
                    begin
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        v_reg <= v_next;
                        e_reg <= e_next;
                    end
                end
                S_ROOT:
                begin
                    g_reg <= g_next;
                    v_reg <= v_next;
                    e_reg <= e_next;
                    i_reg <= i_reg + IW'(1);
                    if (RW'(i_reg) == r_eff - RW'(1))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                end
                default:
                begin
                    state_reg <= S_INIT;
                end
            endcase
        end
    end

    assign red          = poly_reg;
    assign coeff        = g_reg;
    assign status.busy  = (state_reg != S_DONE);
    assign status.clear = (state_reg == S_INIT);

    `RSP_ASSERT_NEXT(a_cfg_restart, cfg_hit, state_reg == S_INIT, "config write did not restart")
    `RSP_ASSERT_HOLDS(a_root_count, state_reg == S_ROOT, RW'(i_reg) < r_eff, "root step overran")
    `RSP_ASSERT_HOLDS(a_pow_bound, state_reg == S_POW, e_reg <= b_mod, "power walk overran")

endmodule

// ===== rtl/rsp_front.sv =====
`timescale 1ns / 1ps
`include "reed_solomon_parity_encoder_assert.svh"

module rsp_front #(
    parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            push,
    output logic                                            full,
    input  rsp_pkg::symbol_t                                message_symbol,
    input  logic                                            last_symbol,
    input  rsp_pkg::gen_status_t                            status,
    input  rsp_pkg::symbol_t                                red,
    input  logic [$clog2(MAX_PARITY+1)-1:0]                 r_eff,
    input  logic [MAX_PARITY-1:0][rsp_pkg::SYMBOL_BITS-1:0] coeff,
    input  logic                                            q_full,
    output logic                                            frame_push,
    output logic [MAX_PARITY-1:0][rsp_pkg::SYMBOL_BITS-1:0] frame_data
);
    import rsp_pkg::*;

    localparam int RW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] rem_reg;
    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] rem_next;
    logic [IW-1:0]                          top_idx;
    symbol_t                                fb;
    logic                                   accept;

    assign full    = status.busy || q_full;
    assign accept  = push && !full;
    assign top_idx = IW'(r_eff - RW'(1));
    assign fb      = message_symbol ^ rem_reg[top_idx];

    // one lfsr step, only the live part of the register moves
    always_comb
    begin
        rem_next[0] = gf_mul(fb, coeff[0], red);
        for (int i = 1; i < MAX_PARITY; i++)
        begin
            if (RW'(i) < r_eff)
            begin
                rem_next[i] = rem_reg[i-1] ^ gf_mul(fb, coeff[i], red);
            end
            else
            begin
                rem_next[i] = rem_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (status.clear)
        begin
            rem_reg <= '0;
        end
        else if (accept)
        begin
            if (last_symbol)
            begin
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= rem_next;
            end
        end
    end

    assign frame_push = accept && last_symbol;
    assign frame_data = rem_next;

    `RSP_ASSERT_NEXT(a_clear_rem, status.clear, rem_reg == '0, "remainder not cleared")
    `RSP_ASSERT_NEXT(a_last_rem, frame_push, rem_reg == '0, "remainder kept after last beat")
    `RSP_ASSERT_HOLDS(a_frame_room, frame_push, !q_full && !status.busy, "frame pushed without room")

endmodule

// ===== rtl/rsp_back.sv =====
`timescale 1ns / 1ps
`include "reed_solomon_parity_encoder_assert.svh"

module rsp_back #(
    parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            frame_push,
    input  logic [MAX_PARITY-1:0][rsp_pkg::SYMBOL_BITS-1:0] frame_data,
    output logic                                            q_full,
    input  logic [$clog2(MAX_PARITY+1)-1:0]                 r_eff,
    input  logic                                            pop,
    output logic                                            empty,
    output rsp_pkg::symbol_t                                parity_symbol,
    output logic [rsp_pkg::IDX_BITS-1:0]                    parity_index,
    output logic                                            parity_last
);
    import rsp_pkg::*;

    localparam int RW = $clog2(MAX_PARITY + 1);
    localparam int IW = $clog2(MAX_PARITY);

    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] q_mem [FRAME_QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]                   wr_ptr_reg;
    logic [QPTR_BITS-1:0]                   rd_ptr_reg;
    logic [QCOUNT_BITS-1:0]                 count_reg;
    logic [IW-1:0]                          off_reg;
    logic                                   out_valid_reg;
    symbol_t                                out_sym_reg;
    logic [IDX_BITS-1:0]                    out_index_reg;
    logic                                   out_last_reg;

    logic [RW-1:0]                          idx;
    symbol_t                                sym;
    logic                                   load;
    logic                                   frame_done;

    assign q_full     = (count_reg == QCOUNT_BITS'(FRAME_QUEUE_DEPTH));
    assign idx        = r_eff - RW'(1) - RW'(off_reg);
    assign sym        = q_mem[rd_ptr_reg][IW'(idx)];
    assign load       = (count_reg != '0) && (!out_valid_reg || pop);
    assign frame_done = load && (idx == '0);

    always_ff @(posedge clk)
    begin
        if (frame_push)
        begin
            q_mem[wr_ptr_reg] <= frame_data;
        end
        if (load)
        begin
            out_sym_reg   <= sym;
            out_index_reg <= IDX_BITS'(idx);
            out_last_reg  <= (idx == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            // serialiser walks the head frame from the top coefficient down
            if (frame_done)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
                off_reg    <= '0;
            end
            else if (load)
            begin
                off_reg <= off_reg + IW'(1);
            end
            count_reg <= count_reg + QCOUNT_BITS'(frame_push) - QCOUNT_BITS'(frame_done);
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty         = !out_valid_reg;
    assign parity_symbol = out_sym_reg;
    assign parity_index  = out_index_reg;
    assign parity_last   = out_last_reg;

    `RSP_ASSERT_HOLDS(a_last_index, out_valid_reg && out_last_reg, out_index_reg == '0, "last beat not index zero")
    `RSP_ASSERT_HOLDS(a_count_range, 1'b1, count_reg <= QCOUNT_BITS'(FRAME_QUEUE_DEPTH), "frame queue overflow")
    `RSP_ASSERT_HOLDS(a_off_idle, count_reg == '0, off_reg == '0, "serialiser offset left over")
    `RSP_ASSERT_HOLDS(a_no_push_full, q_full, !frame_push, "frame pushed into full queue")

endmodule

// ===== rtl/reed_solomon_parity_encoder.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake        beat payload
// message   in         push / full      message_symbol, last_symbol
// parity    out        pop / empty      parity_symbol, parity_index, parity_last
// config    in         cfg_write        cfg_index, cfg_data
//
// one symbol per cycle unless full; the remainder lfsr updates all R taps in that cycle.
// a last beat hands its remainder to a two-frame queue; the serialiser sends R parity
// beats, one per cycle while pop allows, each via the queue and the output register.
// after reset or a write to config index 0-3 the generator walks to alpha^(first_root
// mod 255), then takes R root steps, with full high; the remainder then starts cleared.
// full also rises while both queue frames are taken; a stalled pop holds the output beat.

module reed_solomon_parity_encoder
    #(
        parameter int MAX_PARITY = rsp_pkg::MAX_PARITY_DEF
    ) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [rsp_pkg::SYMBOL_BITS-1:0]    message_symbol,
    input  logic                               last_symbol,
    output logic                               empty,
    input  logic                               pop,
    output logic [rsp_pkg::SYMBOL_BITS-1:0]    parity_symbol,
    output logic [rsp_pkg::IDX_BITS-1:0]       parity_index,
    output logic                               parity_last,
    input  logic                               cfg_write,
    input  logic [rsp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rsp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rsp_pkg::*;

    localparam int RW = $clog2(MAX_PARITY + 1);

    gen_status_t                            status;
    symbol_t                                red;
    logic [RW-1:0]                          r_eff;
    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] coeff;
    logic                                   q_full;
    logic                                   frame_push;
    logic [MAX_PARITY-1:0][SYMBOL_BITS-1:0] frame_data;

    rsp_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .red       (red),
        .r_eff     (r_eff),
        .coeff     (coeff),
        .status    (status)
    );

    rsp_front #(
        .MAX_PARITY (MAX_PARITY)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .message_symbol (message_symbol),
        .last_symbol    (last_symbol),
        .status         (status),
        .red            (red),
        .r_eff          (r_eff),
        .coeff          (coeff),
        .q_full         (q_full),
        .frame_push     (frame_push),
        .frame_data     (frame_data)
    );

    rsp_back #(
        .MAX_PARITY (MAX_PARITY)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_push    (frame_push),
        .frame_data    (frame_data),
        .q_full        (q_full),
        .r_eff         (r_eff),
        .pop           (pop),
        .empty         (empty),
        .parity_symbol (parity_symbol),
        .parity_index  (parity_index),
        .parity_last   (parity_last)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import rsp_pkg::*;

    localparam int MAX_PAR     = MAX_PARITY_DEF;
    localparam int IDLE_PCT    = 34;
    localparam int RAND_ITEMS  = 365;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        symbol_t              sym;
        logic [IDX_BITS-1:0]  idx;
        logic                 is_last;
    } parity_beat_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    symbol_t                   message_symbol;
    logic                      last_symbol;
    logic                      empty;
    logic                      pop;
    symbol_t                   parity_symbol;
    logic [IDX_BITS-1:0]       parity_index;
    logic                      parity_last;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // encoder state as the block should hold it
    logic [POLY_BITS-1:0]      poly_reg;
    symbol_t                   alpha_reg;
    symbol_t                   root_reg;
    logic [RCOUNT_BITS-1:0]    count_reg;
    symbol_t                   gen_coeff [0:MAX_PAR-1];
    symbol_t                   remainder [0:MAX_PAR-1];

    parity_beat_t              expected_parity [$];
    int                        errors = 0;
    int                        items_sent;
    int                        hold_requests = 0;
    logic                      steady;

    reed_solomon_parity_encoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .message_symbol (message_symbol),
        .last_symbol    (last_symbol),
        .empty          (empty),
        .pop            (pop),
        .parity_symbol  (parity_symbol),
        .parity_index   (parity_index),
        .parity_last    (parity_last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // shift-and-add product; bit 8 of the polynomial is always taken as set
    function automatic symbol_t field_mul(symbol_t a, symbol_t b);
        logic [POLY_BITS-1:0] p;
        symbol_t              acc;
        int                   k;
        acc = '0;
        p   = {1'b0, a};
        for (k = 0; k < SYMBOL_BITS; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ p[SYMBOL_BITS-1:0];
            end
            p = {p[SYMBOL_BITS-1:0], 1'b0};
            if (p[SYMBOL_BITS])
            begin
                p = p ^ (poly_reg | POLY_BITS'(1 << SYMBOL_BITS));
            end
        end
        return acc;
    endfunction

    function automatic int active_parity();
        int r;
        r = int'(count_reg);
        if (r < 2)
        begin
            r = 2;
        end
        if (r > MAX_PAR)
        begin
            r = MAX_PAR;
        end
        return r;
    endfunction

    // g(x) = prod (x + alpha^(b+i)), leading one implicit; also starts a fresh block
    task automatic rebuild_generator();
        symbol_t power [0:FIELD_ORDER-1];
        symbol_t poly  [0:MAX_PAR];
        symbol_t root;
        int      r;
        int      i;
        int      k;
        r        = active_parity();
        power[0] = FIELD_ONE;
        for (i = 1; i < FIELD_ORDER; i++)
        begin
            power[i] = field_mul(alpha_reg, power[i-1]);
        end
        for (i = 0; i <= MAX_PAR; i++)
        begin
            poly[i] = '0;
        end
        poly[0] = FIELD_ONE;
        for (i = 0; i < r; i++)
        begin
            root = power[(int'(root_reg) + i) % FIELD_ORDER];
            for (k = i + 1; k > 0; k--)
            begin
                poly[k] = poly[k-1] ^ field_mul(poly[k], root);
            end
            poly[0] = field_mul(poly[0], root);
        end
        for (i = 0; i < MAX_PAR; i++)
        begin
            gen_coeff[i] = poly[i];
            remainder[i] = '0;
        end
    endtask

    // one lfsr step; a last symbol releases the whole remainder, highest degree first
    task automatic absorb_symbol(symbol_t sym, logic is_last);
        parity_beat_t beat;
        symbol_t      fb;
        int           r;
        int           i;
        r  = active_parity();
        fb = sym ^ remainder[r-1];
        for (i = r - 1; i > 0; i--)
        begin
            remainder[i] = remainder[i-1] ^ field_mul(fb, gen_coeff[i]);
        end
        remainder[0] = field_mul(fb, gen_coeff[0]);
        if (is_last)
        begin
            for (i = r - 1; i >= 0; i--)
            begin
                beat.sym     = remainder[i];
                beat.idx     = IDX_BITS'(i);
                beat.is_last = (i == 0);
                expected_parity.push_back(beat);
            end
            for (i = 0; i < MAX_PAR; i++)
            begin
                remainder[i] = '0;
            end
        end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        case (idx)
            CFG_FIELD_POLY:   poly_reg  = value[POLY_BITS-1:0];
            CFG_PRIMITIVE:    alpha_reg = value[SYMBOL_BITS-1:0];
            CFG_FIRST_ROOT:   root_reg  = value[SYMBOL_BITS-1:0];
            CFG_PARITY_COUNT: count_reg = value[RCOUNT_BITS-1:0];
            default:          ;
        endcase
        rebuild_generator();
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic send_symbol(symbol_t sym, logic is_last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push           = 1'b1;
        message_symbol = sym;
        last_symbol    = is_last;
        do
        begin
            @(posedge clk);
        end
        while (full);
        absorb_symbol(sym, is_last);
        items_sent++;
    endtask

    task automatic send_frame(int len);
        int j;
        for (j = 0; j < len; j++)
        begin
            send_symbol(symbol_t'($urandom_range(255)), j == len - 1);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        push = 1'b0;
        while (expected_parity.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // a trailing non-last beat may still be in the lfsr when the last parity has gone
    task automatic quiesce();
        drain_results();
        repeat (10) @(posedge clk);
    endtask

    // receiver: random pop, long hold-offs counted here
    initial
    begin
        int hold_off;
        int hold_seen;
        hold_off  = 0;
        hold_seen = 0;
        pop       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_off  = HOLD_CYCLES;
            end
            if (hold_off > 0)
            begin
                pop = 1'b0;
                hold_off--;
            end
            else if (steady)
            begin
                pop = 1'b1;
            end
            else
            begin
                pop = ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        parity_beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_parity.size() == 0)
            begin
                errors++;
                if (errors < 40)
                begin
                    $display("%0t: parity beat with none expected: sym %02h idx %0d last %0b",
                             $time, parity_symbol, parity_index, parity_last);
                end
            end
            else
            begin
                want = expected_parity.pop_front();
                if (want.sym !== parity_symbol || want.idx !== parity_index
                    || want.is_last !== parity_last)
                begin
                    errors++;
                    if (errors < 40)
                    begin
                        $display("%0t: mismatch: exp %02h/%0d/%0b, got %02h/%0d/%0b",
                                 $time, want.sym, want.idx, want.is_last,
                                 parity_symbol, parity_index, parity_last);
                    end
                end
            end
        end
    end

    task automatic test_default_config();
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b1);
        send_symbol(8'h80, 1'b0);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'hAA, 1'b1);
    endtask

    // counts below 2 act as 2, above 32 as 32
    task automatic test_parity_limits();
        logic [CFG_DATA_BITS-1:0] counts [0:5];
        int                       i;
        counts = '{9'd0, 9'd1, 9'd2, 9'd32, 9'd33, 9'd63};
        for (i = 0; i < 6; i++)
        begin
            quiesce();
            write_reg(CFG_PARITY_COUNT, counts[i]);
            send_symbol(symbol_t'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic test_field_corners();
        quiesce();
        write_reg(CFG_FIELD_POLY, 9'h000);
        write_reg(CFG_PRIMITIVE, 9'h000);
        write_reg(CFG_FIRST_ROOT, 9'h0FF);
        write_reg(CFG_PARITY_COUNT, 9'd4);
        send_symbol(8'h5A, 1'b0);
        send_symbol(8'hC3, 1'b1);
        quiesce();
        write_reg(CFG_FIELD_POLY, 9'h1FF);
        write_reg(CFG_PRIMITIVE, 9'h001);
        write_reg(CFG_FIRST_ROOT, 9'h0FE);
        send_symbol(8'hFF, 1'b1);
        quiesce();
        write_reg(CFG_FIELD_POLY, 9'h100);
        write_reg(CFG_PRIMITIVE, 9'h0FF);
        send_symbol(8'h7F, 1'b1);
        quiesce();
        write_reg(CFG_FIELD_POLY, 9'h12B);
        write_reg(CFG_PRIMITIVE, 9'h003);
        write_reg(CFG_FIRST_ROOT, 9'h001);
        write_reg(CFG_PARITY_COUNT, 9'd16);
        send_symbol(8'h01, 1'b0);
        send_symbol(8'hFE, 1'b1);
    endtask

    // a register write drops a half-built block
    task automatic test_write_clears_block();
        quiesce();
        send_symbol(8'h3C, 1'b0);
        send_symbol(8'hE1, 1'b0);
        send_symbol(8'h96, 1'b0);
        quiesce();
        write_reg(CFG_FIRST_ROOT, 9'h011);
        send_symbol(8'h42, 1'b1);
    endtask

    // receiver stops long enough for both frame slots to fill and push to stall
    task automatic test_output_stall();
        int i;
        quiesce();
        write_reg(CFG_FIELD_POLY, 9'h11D);
        write_reg(CFG_PRIMITIVE, 9'h002);
        write_reg(CFG_PARITY_COUNT, 9'd6);
        hold_requests++;
        for (i = 0; i < 10; i++)
        begin
            send_frame(2);
        end
        drain_results();
        send_frame(3);
    endtask

    task automatic test_random_frames();
        int target;
        int phase;
        int phase_end;
        int len;
        target = items_sent + RAND_ITEMS;
        phase  = 0;
        while (items_sent < target)
        begin
            quiesce();
            if ($urandom_range(2) != 0)
            begin
                write_reg(CFG_FIELD_POLY, 9'($urandom_range(511)));
            end
            if ($urandom_range(2) != 0)
            begin
                write_reg(CFG_PRIMITIVE, 9'($urandom_range(511)));
            end
            if ($urandom_range(2) != 0)
            begin
                write_reg(CFG_FIRST_ROOT, 9'($urandom_range(511)));
            end
            if ($urandom_range(2) != 0)
            begin
                write_reg(CFG_PARITY_COUNT, 9'($urandom_range(511)));
            end
            // one phase runs flat out on both sides
            steady    = (phase == 3);
            phase_end = items_sent + $urandom_range(25, 55);
            while (items_sent < phase_end && items_sent < target)
            begin
                if ($urandom_range(9) == 0)
                begin
                    len = $urandom_range(20, 60);
                end
                else
                begin
                    len = $urandom_range(1, 8);
                end
                send_frame(len);
                if ($urandom_range(5) == 0)
                begin
                    drain_results();
                end
            end
            steady = 1'b0;
            phase++;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        message_symbol = '0;
        last_symbol    = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_FIELD_POLY;
        cfg_data       = '0;
        steady         = 1'b0;
        items_sent     = 0;
        poly_reg       = {1'b1, RST_POLY_LOW};
        alpha_reg      = RST_PRIMITIVE;
        root_reg       = RST_FIRST_ROOT;
        count_reg      = RST_PARITY_CNT;
        rebuild_generator();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_config();
        test_parity_limits();
        test_field_corners();
        test_write_clears_block();
        test_output_stall();
        test_random_frames();

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
